@@ rtl/core/bf3_pkg.sv @@
// Shared types and constants for the 3x3 box filter.
// No dependencies; the other files in rtl/core but bf3_ram refer to it by scoped names.
package bf3_pkg;

   localparam int PIX_W       = 8;
   localparam int COL_W       = 10;   // sum of three pixels
   localparam int SUM_W       = 12;   // sum of nine pixels
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 16;
   localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;   // ceil(2^16 / 9)

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int REG_W      = 11;

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam logic [REG_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [REG_W-1:0] FRAME_HEIGHT_RESET = 11'd480;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_in;
      logic             drain;
   } bf3_req_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             frame_end;
   } bf3_rsp_type;

   // Scan decisions for one beat, carried with it into the line buffer stage
   typedef struct packed {
      logic [PIX_W-1:0] px;
      logic             emit;
      logic             interior;
      logic             last;
   } bf3_tok_type;

   // Window stage result handed to the divide stage
   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [PIX_W-1:0] centre;
      logic             interior;
      logic             last;
   } bf3_win_type;

endpackage

@@ rtl/core/box_filter_3x3.sv @@
// Top level of the 3x3 box filter: register port, scan, line buffer and divide stages.
// Depends on bf3_pkg, bf3_scan, bf3_window, bf3_mean.
//
// channel  ports                          payload          direction
// req      req_valid req_stall req_data   pixel_in, drain  in
// rsp      rsp_valid rsp_stall rsp_data   pixel_out, frame_end out
// csr      psel penable pwrite paddr ...  frame_width @0x0, frame_height @0x4
//
// One beat per cycle if rsp_stall is low; line buffer RAM: one read and one write per cycle.
// Beat k+width+1 completes result k's window; it then passes s1, s2 and the output register.
// Reset sets counters, valid flags and frame size; line buffers hold stale data, no clear pass.
// rsp_stall holds the output register; req_stall rises only when all three stages are full.
module box_filter_3x3 #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  bf3_pkg::bf3_req_type               req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output bf3_pkg::bf3_rsp_type               rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [bf3_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [bf3_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [bf3_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int DW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   logic [bf3_pkg::REG_W-1:0] width_ff;
   logic [bf3_pkg::REG_W-1:0] height_ff;
   logic [DW-1:0]             frame_w;
   logic [HW-1:0]             frame_h;
   logic                      cfg_wr;
   logic                      accept;
   logic                      take_ok;
   logic                      tok_valid;
   bf3_pkg::bf3_tok_type      tok;
   logic [CW-1:0]             tok_addr;
   logic                      frame_start;
   logic                      win_valid;
   bf3_pkg::bf3_win_type      win;
   logic                      out_ready;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bf3_pkg::FRAME_WIDTH_RESET;
         height_ff <= bf3_pkg::FRAME_HEIGHT_RESET;
      end else if (cfg_wr) begin
         case (paddr[2])
            bf3_pkg::REG_FRAME_WIDTH:  width_ff  <= pwdata[bf3_pkg::REG_W-1:0];
            bf3_pkg::REG_FRAME_HEIGHT: height_ff <= pwdata[bf3_pkg::REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         bf3_pkg::REG_FRAME_WIDTH:  prdata = bf3_pkg::CSR_DATA_W'(width_ff);
         bf3_pkg::REG_FRAME_HEIGHT: prdata = bf3_pkg::CSR_DATA_W'(height_ff);
         default:                   prdata = '0;
      endcase

      if (width_ff == '0) begin
         frame_w = DW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         frame_w = DW'(MAX_WIDTH);
      end else begin
         frame_w = DW'(width_ff);
      end

      if (height_ff == '0) begin
         frame_h = HW'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         frame_h = HW'(MAX_HEIGHT);
      end else begin
         frame_h = HW'(height_ff);
      end
   end

   assign req_stall = !take_ok;
   assign accept    = req_valid && !req_stall;

   bf3_scan #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .restart     (cfg_wr),
      .frame_w     (frame_w),
      .frame_h     (frame_h),
      .accept      (accept),
      .req_data    (req_data),
      .tok_valid   (tok_valid),
      .tok         (tok),
      .tok_addr    (tok_addr),
      .frame_start (frame_start)
   );

   bf3_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (tok_valid),
      .tok       (tok),
      .tok_addr  (tok_addr),
      .take_ok   (take_ok),
      .win_valid (win_valid),
      .win       (win),
      .out_ready (out_ready)
   );

   bf3_mean u_mean (
      .clock     (clock),
      .reset     (reset),
      .win_valid (win_valid),
      .win       (win),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while output side can move");

   a_reset_empties_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present right after reset");

   a_write_restarts_frame: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> frame_start)
      else $error("register write did not restart the frame");

endmodule

@@ rtl/core/bf3_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module bf3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/bf3_scan.sv @@
// Raster position counters for input and output; classifies each beat.
// Depends on bf3_pkg.
module bf3_scan #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              restart,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]    frame_w,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]   frame_h,
   input  logic                              accept,
   input  bf3_pkg::bf3_req_type              req_data,
   output logic                              tok_valid,
   output bf3_pkg::bf3_tok_type              tok,
   output logic [$clog2(MAX_WIDTH)-1:0]      tok_addr,
   output logic                              frame_start
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT + 2);
   localparam int ORW = $clog2(MAX_HEIGHT);

   logic [CW-1:0]  in_col_ff, in_col_in;
   logic [RW-1:0]  in_row_ff, in_row_in;
   logic [CW-1:0]  out_col_ff, out_col_in;
   logic [ORW-1:0] out_row_ff, out_row_in;

   logic           flushing;
   logic [CW:0]    col_nx;
   logic [CW:0]    ocol_nx;
   logic [ORW:0]   orow_nx;
   logic           col_wrap;
   logic           ocol_wrap;

   always_comb begin
      flushing  = in_row_ff >= RW'(frame_h);
      col_nx    = {1'b0, in_col_ff} + (CW+1)'(1);
      ocol_nx   = {1'b0, out_col_ff} + (CW+1)'(1);
      orow_nx   = {1'b0, out_row_ff} + (ORW+1)'(1);
      col_wrap  = col_nx >= (CW+1)'(frame_w);
      ocol_wrap = ocol_nx >= (CW+1)'(frame_w);

      tok_valid    = accept && !(req_data.drain && !flushing);
      tok.px       = flushing ? '0 : req_data.pixel_in;
      tok.emit     = (in_row_ff > RW'(1)) || ((in_row_ff == RW'(1)) && (in_col_ff != '0));
      tok.interior = (out_row_ff != '0) && (orow_nx < (ORW+1)'(frame_h)) &&
                     (out_col_ff != '0) && !ocol_wrap;
      tok.last     = (orow_nx >= (ORW+1)'(frame_h)) && ocol_wrap;
      tok_addr     = in_col_ff;

      frame_start  = (in_col_ff == '0) && (in_row_ff == '0) &&
                     (out_col_ff == '0) && (out_row_ff == '0);

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (tok_valid) begin
         if (col_wrap) begin
            in_col_in = '0;
            in_row_in = in_row_ff + RW'(1);
         end else begin
            in_col_in = col_nx[CW-1:0];
         end
         if (tok.emit) begin
            if (tok.last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (ocol_wrap) begin
               out_col_in = '0;
               out_row_in = orow_nx[ORW-1:0];
            end else begin
               out_col_in = ocol_nx[CW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

endmodule

@@ rtl/core/bf3_window.sv @@
// Line buffer stage (read-modify-write of the paired row store) and window sum stage.
// Depends on bf3_pkg and bf3_ram.
module bf3_window #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          tok_valid,
   input  bf3_pkg::bf3_tok_type          tok,
   input  logic [$clog2(MAX_WIDTH)-1:0]  tok_addr,
   output logic                          take_ok,
   output logic                          win_valid,
   output bf3_pkg::bf3_win_type          win,
   input  logic                          out_ready
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int PW  = bf3_pkg::PIX_W;
   localparam int LW  = 2 * bf3_pkg::PIX_W;

   logic                             s1_v_ff;
   bf3_pkg::bf3_tok_type             s1_tok_ff;
   logic [CW-1:0]                    s1_addr_ff;
   logic                             s1_fwd_ff;
   logic [LW-1:0]                    fwd_data_ff;

   logic [bf3_pkg::COL_W-1:0]        cs1_ff;
   logic [bf3_pkg::COL_W-1:0]        cs2_ff;
   logic [PW-1:0]                    mid_ff;

   logic                             s2_v_ff;
   bf3_pkg::bf3_win_type             s2_data_ff;

   logic [LW-1:0]                    rd_data;
   logic [LW-1:0]                    line;
   logic [PW-1:0]                    s1_top;
   logic [PW-1:0]                    s1_mid;
   logic [bf3_pkg::COL_W-1:0]        new_col;
   logic                             s2_open;
   logic                             s1_leave;
   logic                             s1_emit_go;

   bf3_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_leave),
      .wr_addr (s1_addr_ff),
      .wr_data ({s1_mid, s1_tok_ff.px}),
      .rd_en   (tok_valid),
      .rd_addr (tok_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      line       = s1_fwd_ff ? fwd_data_ff : rd_data;
      s1_top     = line[LW-1:PW];
      s1_mid     = line[PW-1:0];
      new_col    = bf3_pkg::COL_W'(s1_top) + bf3_pkg::COL_W'(s1_mid) +
                   bf3_pkg::COL_W'(s1_tok_ff.px);
      s2_open    = !s2_v_ff || out_ready;
      s1_leave   = s1_v_ff && (!s1_tok_ff.emit || s2_open);
      s1_emit_go = s1_leave && s1_tok_ff.emit;
      take_ok    = !s1_v_ff || s1_leave;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= tok_valid || (s1_v_ff && !s1_leave);
         s2_v_ff <= s1_emit_go || (s2_v_ff && !out_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (tok_valid) begin
         s1_tok_ff   <= tok;
         s1_addr_ff  <= tok_addr;
         // forward the entry being written back this cycle
         s1_fwd_ff   <= s1_v_ff && (tok_addr == s1_addr_ff);
         fwd_data_ff <= {s1_mid, s1_tok_ff.px};
      end
      if (s1_leave) begin
         cs1_ff <= cs2_ff;
         cs2_ff <= new_col;
         mid_ff <= s1_mid;
      end
      if (s1_emit_go) begin
         s2_data_ff.sum      <= bf3_pkg::SUM_W'(cs1_ff) + bf3_pkg::SUM_W'(cs2_ff) +
                                bf3_pkg::SUM_W'(new_col);
         s2_data_ff.centre   <= mid_ff;
         s2_data_ff.interior <= s1_tok_ff.interior;
         s2_data_ff.last     <= s1_tok_ff.last;
      end
   end

   assign win_valid = s2_v_ff;
   assign win       = s2_data_ff;

endmodule

@@ rtl/core/bf3_mean.sv @@
// Divide-by-nine by reciprocal multiply, border select and output register.
// Depends on bf3_pkg.
module bf3_mean (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  win_valid,
   input  bf3_pkg::bf3_win_type  win,
   output logic                  out_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bf3_pkg::bf3_rsp_type  rsp_data
);

   localparam int PW = bf3_pkg::SUM_W + bf3_pkg::RECIP_W;

   logic                  out_v_ff;
   bf3_pkg::bf3_rsp_type  out_data_ff;
   logic [PW-1:0]         prod;
   logic [bf3_pkg::PIX_W-1:0] quot;

   always_comb begin
      out_ready = !out_v_ff || !rsp_stall;
      prod      = PW'(win.sum) * PW'(bf3_pkg::RECIP_NINE);
      quot      = prod[bf3_pkg::RECIP_SHIFT +: bf3_pkg::PIX_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_ready) begin
         out_v_ff <= win_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && win_valid) begin
         out_data_ff.pixel_out <= win.interior ? quot : win.centre;
         out_data_ff.frame_end <= win.last;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_data_ff;

endmodule

@@ dv/tb_box_filter_3x3.sv @@
// Self-checking testbench for box_filter_3x3: a scripted opening, a frame against a parked sink,
// then random frames with random idling on both channels, each result checked in order.
// Depends on bf3_pkg and the box_filter_3x3 RTL; needs nothing else.
`timescale 1ns / 100ps

module tb_box_filter_3x3;

   localparam int unsigned LINE_MAX      = 1024;
   localparam int unsigned ROWS_MAX      = 1024;
   localparam int unsigned NEIGHBOURS    = 9;
   localparam int unsigned SETTLE_CYCLES = 12;
   localparam int unsigned PARK_CYCLES   = 300;
   localparam int unsigned STALL_LIMIT   = 2000;
   localparam int unsigned RANDOM_BEATS  = 780;

   typedef enum logic [1:0] {STEP_BEAT, STEP_WIDTH, STEP_HEIGHT} step_kind_type;

   typedef struct packed {
      step_kind_type                kind;
      logic [bf3_pkg::REG_W-1:0]    value;
      bf3_pkg::bf3_req_type         beat;
      logic                         typed;
      bf3_pkg::bf3_rsp_type         want;
   } script_step_type;

   localparam bf3_pkg::bf3_req_type DRAIN_BEAT = '{8'h00, 1'b1};
   localparam bf3_pkg::bf3_req_type NO_BEAT    = '0;
   localparam bf3_pkg::bf3_rsp_type NO_RSP     = '0;

   localparam int SCRIPT_LEN = 22;
   localparam script_step_type SCRIPT [SCRIPT_LEN] = '{
      '{STEP_WIDTH,  11'd3, NO_BEAT,          1'b0, NO_RSP},
      '{STEP_HEIGHT, 11'd3, NO_BEAT,          1'b0, NO_RSP},
      '{STEP_BEAT,   11'd0, DRAIN_BEAT,       1'b0, NO_RSP},
      '{STEP_BEAT,   11'd0, '{8'h01, 1'b0},   1'b0, NO_RSP},
      '{STEP_BEAT,   11'd0, '{8'h80, 1'b0},   1'b0, NO_RSP},
      '{STEP_BEAT,   11'd0, '{8'hFF, 1'b0},   1'b0, NO_RSP},
      '{STEP_BEAT,   11'd0, '{8'hFE, 1'b0},   1'b0, NO_RSP},
      '{STEP_BEAT,   11'd0, '{8'hFF, 1'b0},   1'b1, '{8'h01, 1'b0}},
      '{STEP_BEAT,   11'd0, '{8'h7F, 1'b0},   1'b1, '{8'h80, 1'b0}},
      '{STEP_BEAT,   11'd0, '{8'h00, 1'b0},   1'b1, '{8'hFF, 1'b0}},
      '{STEP_BEAT,   11'd0, '{8'h55, 1'b0},   1'b1, '{8'hFE, 1'b0}},
      '{STEP_BEAT,   11'd0, '{8'hAA, 1'b0},   1'b0, NO_RSP},
      '{STEP_BEAT,   11'd0, DRAIN_BEAT,       1'b1, '{8'h7F, 1'b0}},
      '{STEP_BEAT,   11'd0, '{8'h5A, 1'b0},   1'b1, '{8'h00, 1'b0}},
      '{STEP_BEAT,   11'd0, DRAIN_BEAT,       1'b1, '{8'h55, 1'b0}},
      '{STEP_BEAT,   11'd0, DRAIN_BEAT,       1'b1, '{8'hAA, 1'b1}},
      '{STEP_BEAT,   11'd0, DRAIN_BEAT,       1'b0, NO_RSP},
      '{STEP_WIDTH,  11'd0, NO_BEAT,          1'b0, NO_RSP},
      '{STEP_HEIGHT, 11'd0, NO_BEAT,          1'b0, NO_RSP},
      '{STEP_BEAT,   11'd0, '{8'hC3, 1'b0},   1'b0, NO_RSP},
      '{STEP_BEAT,   11'd0, DRAIN_BEAT,       1'b0, NO_RSP},
      '{STEP_BEAT,   11'd0, DRAIN_BEAT,       1'b1, '{8'hC3, 1'b1}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_valid;
   logic                           req_stall;
   bf3_pkg::bf3_req_type           req_data;
   logic                           rsp_valid;
   logic                           rsp_stall;
   bf3_pkg::bf3_rsp_type           rsp_data;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [bf3_pkg::CSR_ADDR_W-1:0] paddr;
   logic [bf3_pkg::CSR_DATA_W-1:0] pwdata;
   logic [bf3_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   box_filter_3x3 #(.MAX_WIDTH(LINE_MAX), .MAX_HEIGHT(ROWS_MAX)) dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mean filter state mirrored in the testbench
   logic [bf3_pkg::PIX_W-1:0] row_two_up [LINE_MAX];
   logic [bf3_pkg::PIX_W-1:0] row_one_up [LINE_MAX];
   logic [bf3_pkg::PIX_W-1:0] win [NEIGHBOURS];
   logic [bf3_pkg::REG_W-1:0] cfg_width;
   logic [bf3_pkg::REG_W-1:0] cfg_height;
   int unsigned               scan_col, scan_row, emit_col, emit_row;

   bf3_pkg::bf3_rsp_type expected_pixels [$];
   int unsigned mismatches;
   int unsigned fed_beats;
   int unsigned req_gap_max;
   int unsigned rsp_gap_max;
   logic        park_request;

   function automatic int unsigned eff_dim(input logic [bf3_pkg::REG_W-1:0] v,
                                           input int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return 32'(v);
   endfunction

   function automatic void restart_scan();
      scan_col = 0;
      scan_row = 0;
      emit_col = 0;
      emit_row = 0;
   endfunction

   function automatic logic mean3x3_step(input bf3_pkg::bf3_req_type beat,
                                         output bf3_pkg::bf3_rsp_type res);
      int unsigned w, h, c, sum, r, i;
      logic flushing, emit, last;
      logic [bf3_pkg::PIX_W-1:0] px, top, mid;
      w = eff_dim(cfg_width, LINE_MAX);
      h = eff_dim(cfg_height, ROWS_MAX);
      res = '0;
      flushing = scan_row >= h;
      px = flushing ? '0 : beat.pixel_in;
      if (beat.drain && !flushing) return 1'b0;
      emit = (scan_row > 1) || (scan_row == 1 && scan_col >= 1);
      c = (scan_col >= LINE_MAX) ? LINE_MAX - 1 : scan_col;
      top = row_two_up[c];
      mid = row_one_up[c];
      row_two_up[c] = mid;
      row_one_up[c] = px;
      for (r = 0; r < 3; r++) begin
         win[r*3]     = win[r*3 + 1];
         win[r*3 + 1] = win[r*3 + 2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = px;
      scan_col++;
      if (scan_col >= w) begin
         scan_col = 0;
         scan_row++;
      end
      if (!emit) return 1'b0;
      if (emit_row >= 1 && emit_row + 1 < h && emit_col >= 1 && emit_col + 1 < w) begin
         sum = 0;
         for (i = 0; i < NEIGHBOURS; i++) sum += win[i];
         res.pixel_out = bf3_pkg::PIX_W'(sum / NEIGHBOURS);
      end else begin
         res.pixel_out = win[4];
      end
      last = (emit_row + 1 >= h) && (emit_col + 1 >= w);
      res.frame_end = last;
      if (last) begin
         restart_scan();
      end else begin
         emit_col++;
         if (emit_col >= w) begin
            emit_col = 0;
            emit_row++;
         end
      end
      return 1'b1;
   endfunction

   function automatic logic [bf3_pkg::REG_W-1:0] pick_dim(input int unsigned top);
      if ($urandom_range(0, 9) == 0) return '0;
      return bf3_pkg::REG_W'($urandom_range(1, top));
   endfunction

   task automatic pick_pace();
      req_gap_max = ($urandom_range(0, 1) == 1) ? 5 : 0;
      rsp_gap_max = ($urandom_range(0, 1) == 1) ? 5 : 0;
   endtask

   task automatic offer_beat(input bf3_pkg::bf3_req_type beat, input logic typed,
                             input bf3_pkg::bf3_rsp_type want);
      int unsigned gap;
      bf3_pkg::bf3_rsp_type predicted;
      logic produces;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      produces = mean3x3_step(beat, predicted);
      if (typed) expected_pixels.push_back(want);
      else if (produces) expected_pixels.push_back(predicted);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_frame_reg(input logic idx, input logic [bf3_pkg::REG_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= bf3_pkg::CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= {(bf3_pkg::CSR_DATA_W - bf3_pkg::REG_W)'($urandom()), value};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (idx == bf3_pkg::REG_FRAME_WIDTH) cfg_width = value;
      else cfg_height = value;
      restart_scan();
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic feed_frame(input logic cut_short);
      int unsigned w, h, pixels, total, n;
      bf3_pkg::bf3_req_type beat;
      w = eff_dim(cfg_width, LINE_MAX);
      h = eff_dim(cfg_height, ROWS_MAX);
      pixels = w * h;
      if (cut_short) pixels = $urandom_range(1, pixels);
      total = cut_short ? pixels : pixels + w + 1;
      for (n = 0; n < total; n++) begin
         if (n < pixels && $urandom_range(0, 9) == 0) offer_beat(DRAIN_BEAT, 1'b0, NO_RSP);
         beat.drain = (n >= pixels) && ($urandom_range(0, 5) != 0);
         case ($urandom_range(0, 7))
            0: beat.pixel_in = '0;
            1: beat.pixel_in = '1;
            default: beat.pixel_in = bf3_pkg::PIX_W'($urandom_range(0, 255));
         endcase
         offer_beat(beat, 1'b0, NO_RSP);
         fed_beats++;
      end
      if ($urandom_range(0, 3) == 0) offer_beat(DRAIN_BEAT, 1'b0, NO_RSP);
   endtask

   initial begin : result_sink
      int unsigned hold;
      bf3_pkg::bf3_rsp_type want;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         hold = $urandom_range(0, rsp_gap_max);
         if (park_request) begin
            park_request = 1'b0;
            hold = PARK_CYCLES;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (expected_pixels.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected beat, pixel_out %0d frame_end %0b", $time,
                     rsp_data.pixel_out, rsp_data.frame_end);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_data.pixel_out !== want.pixel_out) begin
               mismatches++;
               $display("%0t: pixel_out expected %0d actual %0d", $time,
                        want.pixel_out, rsp_data.pixel_out);
            end
            if (rsp_data.frame_end !== want.frame_end) begin
               mismatches++;
               $display("%0t: frame_end expected %0b actual %0b", $time,
                        want.frame_end, rsp_data.frame_end);
            end
         end
         @(negedge clock);
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no beat moved for %0d cycles", $time, quiet);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      int i;
      req_valid    = 1'b0;
      req_data     = '0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      mismatches   = 0;
      fed_beats    = 0;
      park_request = 1'b0;
      req_gap_max  = 5;
      rsp_gap_max  = 5;
      for (i = 0; i < LINE_MAX; i++) begin
         row_two_up[i] = '0;
         row_one_up[i] = '0;
      end
      for (i = 0; i < NEIGHBOURS; i++) win[i] = '0;
      cfg_width  = bf3_pkg::FRAME_WIDTH_RESET;
      cfg_height = bf3_pkg::FRAME_HEIGHT_RESET;
      restart_scan();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      pick_pace();
      for (i = 0; i < SCRIPT_LEN; i++) begin
         case (SCRIPT[i].kind)
            STEP_WIDTH: begin
               settle();
               write_frame_reg(bf3_pkg::REG_FRAME_WIDTH, SCRIPT[i].value);
            end
            STEP_HEIGHT: begin
               settle();
               write_frame_reg(bf3_pkg::REG_FRAME_HEIGHT, SCRIPT[i].value);
            end
            default: offer_beat(SCRIPT[i].beat, SCRIPT[i].typed, SCRIPT[i].want);
         endcase
      end

      // hold the sink off while the sender runs flat out
      settle();
      req_gap_max = 0;
      rsp_gap_max = 5;
      write_frame_reg(bf3_pkg::REG_FRAME_WIDTH, 11'd12);
      write_frame_reg(bf3_pkg::REG_FRAME_HEIGHT, 11'd8);
      park_request = 1'b1;
      feed_frame(1'b0);

      fed_beats = 0;
      while (fed_beats < RANDOM_BEATS) begin
         settle();
         pick_pace();
         case ($urandom_range(0, 3))
            0: write_frame_reg(bf3_pkg::REG_FRAME_WIDTH, pick_dim(12));
            1: write_frame_reg(bf3_pkg::REG_FRAME_HEIGHT, pick_dim(8));
            default: begin
               write_frame_reg(bf3_pkg::REG_FRAME_HEIGHT, pick_dim(8));
               write_frame_reg(bf3_pkg::REG_FRAME_WIDTH, pick_dim(12));
            end
         endcase
         repeat ($urandom_range(1, 3)) feed_frame(1'b0);
         if ($urandom_range(0, 4) == 0) feed_frame(1'b1);
      end

      settle();
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/bf3_pkg.sv
rtl/core/bf3_ram.sv
rtl/core/bf3_scan.sv
rtl/core/bf3_window.sv
rtl/core/bf3_mean.sv
rtl/core/box_filter_3x3.sv
dv/tb_box_filter_3x3.sv
